[src/sdfc_pkg.sv]
package sdfc_pkg;

  localparam int DistW  = 32;
  localparam int CoefW  = 31;
  localparam int ModeW  = 2;
  localparam int IndexW = 2;
  localparam int QueueDepth = 2;

  localparam logic [DistW-1:0] DIST_MAX = 32'h7FFF_FFFF;

  typedef enum logic [ModeW-1:0] {
    MODE_UNION = 2'd0,
    MODE_INTER = 2'd1,
    MODE_SUB   = 2'd2,
    MODE_VOID  = 2'd3
  } mode_t;

  typedef enum logic [IndexW-1:0] {
    REG_MODE   = 2'd0,
    REG_FACTOR = 2'd1,
    REG_RECIP  = 2'd2,
    REG_NONE   = 2'd3
  } reg_index_t;

  // What the back end does with a child
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_VOID   = 2'd1,
    OP_HARD   = 2'd2,
    OP_SMOOTH = 2'd3
  } op_t;

  typedef struct packed {
    mode_t            mode;
    logic [CoefW-1:0] factor;
    logic [CoefW-1:0] recip;
  } cfg_t;

  typedef struct packed {
    logic signed [DistW-1:0] distance;
    logic                    last;
    op_t                     op;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_CLAMP  = 3'd1,
    ST_MUL_KH = 3'd2,
    ST_MUL_W  = 3'd3,
    ST_SUM    = 3'd4
  } state_t;

endpackage

[src/sdfc_front.sv]
module sdfc_front
  import sdfc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DistW-1:0] in_dist,
  input  logic                    in_last,
  output logic                    push,
  output item_t                   push_item,
  input  logic                    queue_full
);

  logic awaiting_first;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_item.distance = in_dist;
    push_item.last     = in_last;
    if (cfg.mode == MODE_VOID) begin
      push_item.op = OP_VOID;
    end else if (awaiting_first) begin
      push_item.op = OP_LOAD;
    end else if (cfg.factor == '0) begin
      push_item.op = OP_HARD;
    end else begin
      push_item.op = OP_SMOOTH;
    end
  end

  // Track run boundaries at the accept point
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first <= 1'b1;
    end else if (push) begin
      awaiting_first <= in_last;
    end
  end

endmodule

[src/sdfc_queue.sv]
module sdfc_queue
  import sdfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t            entries [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = (count == CntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/sdfc_back.sv]
module sdfc_back
  import sdfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             head_valid,
  input  item_t            head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DistW-1:0] out_dist
);

  function automatic logic signed [DistW-1:0] sat_dist(input logic signed [37:0] v);
    logic signed [37:0] hi;
    logic signed [37:0] lo;
    hi = 38'sh0_7FFF_FFFF;
    lo = -38'sh0_8000_0000;
    if (v > hi) begin
      sat_dist = hi[DistW-1:0];
    end else if (v < lo) begin
      sat_dist = lo[DistW-1:0];
    end else begin
      sat_dist = v[DistW-1:0];
    end
  endfunction

  state_t                  state;
  state_t                  state_next;
  logic signed [DistW-1:0] acc;
  logic signed [DistW-1:0] d_reg;
  logic                    last_reg;
  logic signed [64:0]      t_reg;
  logic [16:0]             h_reg;
  logic [31:0]             kh_reg;
  logic signed [35:0]      mix_reg;
  logic [32:0]             w_reg;

  logic                    acc_load;
  logic signed [DistW-1:0] acc_value;
  logic                    out_load;
  logic [DistW-1:0]        out_value;
  logic                    out_room;

  logic signed [32:0]      x_val;
  logic signed [64:0]      t_prod;
  logic signed [47:0]      t_shift;
  logic signed [48:0]      h_raw;
  logic [16:0]             h_clamp;
  logic [47:0]             kh_prod;
  logic signed [33:0]      diff;
  logic signed [51:0]      mix_prod;
  logic [16:0]             h_inv;
  logic [48:0]             w_prod;
  logic signed [37:0]      base;
  logic signed [37:0]      sum;
  logic signed [32:0]      neg_d;
  logic signed [DistW-1:0] hard_r;

  assign out_room = !out_valid || out_ready;

  // Blend argument from the head child and the settled accumulator
  always_comb begin
    if (cfg.mode == MODE_SUB) begin
      x_val = 33'(acc) + 33'(head_item.distance);
    end else begin
      x_val = 33'(head_item.distance) - 33'(acc);
    end
    t_prod = 65'(x_val) * $signed({34'd0, cfg.recip});
  end

  always_comb begin
    t_shift = t_reg[64:17];
    if (cfg.mode == MODE_UNION) begin
      h_raw = 49'sd32768 + 49'(t_shift);
    end else begin
      h_raw = 49'sd32768 - 49'(t_shift);
    end
    if (h_raw < 0) begin
      h_clamp = '0;
    end else if (h_raw > 49'sd65536) begin
      h_clamp = 17'd65536;
    end else begin
      h_clamp = h_raw[16:0];
    end
  end

  always_comb begin
    kh_prod = 48'(cfg.factor) * 48'(h_reg);
    if (cfg.mode == MODE_SUB) begin
      diff = -34'(d_reg) - 34'(acc);
    end else begin
      diff = 34'(acc) - 34'(d_reg);
    end
    mix_prod = 52'(diff) * $signed({35'd0, h_reg});
    h_inv    = 17'd65536 - h_reg;
    w_prod   = 49'(kh_reg) * 49'(h_inv);
  end

  always_comb begin
    base = (cfg.mode == MODE_SUB) ? 38'(acc) : 38'(d_reg);
    if (cfg.mode == MODE_UNION) begin
      sum = base + 38'(mix_reg) - $signed({5'd0, w_reg});
    end else begin
      sum = base + 38'(mix_reg) + $signed({5'd0, w_reg});
    end
  end

  // Hard min / max; subtraction can overflow on the most negative child
  always_comb begin
    neg_d = -33'(head_item.distance);
    case (cfg.mode)
      MODE_UNION: hard_r = (head_item.distance < acc) ? head_item.distance : acc;
      MODE_INTER: hard_r = (head_item.distance > acc) ? head_item.distance : acc;
      default:    hard_r = (neg_d > 33'(acc)) ? sat_dist(38'(neg_d)) : acc;
    endcase
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    acc_load   = 1'b0;
    acc_value  = acc;
    out_load   = 1'b0;
    out_value  = acc;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          if (head_item.op == OP_SMOOTH) begin
            pop        = 1'b1;
            state_next = ST_CLAMP;
          end else if (!head_item.last || out_room) begin
            pop       = 1'b1;
            acc_load  = 1'b1;
            acc_value = (head_item.op == OP_HARD) ? hard_r : head_item.distance;
            out_load  = head_item.last;
            out_value = (head_item.op == OP_VOID) ? DIST_MAX : acc_value;
          end
        end
      end
      ST_CLAMP:  state_next = ST_MUL_KH;
      ST_MUL_KH: state_next = ST_MUL_W;
      ST_MUL_W:  state_next = ST_SUM;
      ST_SUM: begin
        // Hold the finished fold of a last child until the output register has room
        if (!last_reg || out_room) begin
          acc_load   = 1'b1;
          acc_value  = sat_dist(sum);
          out_load   = last_reg;
          out_value  = acc_value;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (acc_load) begin
        acc <= acc_value;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dist <= out_value;
    end
    if (state == ST_IDLE && pop) begin
      d_reg    <= head_item.distance;
      last_reg <= head_item.last;
      t_reg    <= t_prod;
    end
    if (state == ST_CLAMP) begin
      h_reg <= h_clamp;
    end
    if (state == ST_MUL_KH) begin
      kh_reg  <= kh_prod[47:16];
      mix_reg <= mix_prod[51:16];
    end
    if (state == ST_MUL_W) begin
      w_reg <= w_prod[48:16];
    end
  end

endmodule

[src/sdf_csg_smooth_combiner.sv]
// Smooth CSG combiner: folds a run of Q16.16 child distances into one distance.
// Back end: a loaded or hard-combined child is folded into the accumulator as it is popped; a
// smooth-blended child steps through multiply, clamp, two multiplies, sum on the accumulator.
// The last child's result goes via the queue (and the blend steps) to the output register, held while it is full.
// A 2-entry queue lets children be accepted while the back end is busy.
// Reset (rst, synchronous): config registers and accumulator clear, next child opens a run.
module sdf_csg_smooth_combiner
  import sdfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DistW-1:0]  s_tdata,   // [31:0] child_distance
  input  logic              s_tlast,   // last_child
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DistW-1:0]  m_tdata,   // [31:0] combined_distance
  input  logic              cfg_we,
  input  logic [IndexW-1:0] cfg_index,
  input  logic [CoefW-1:0]  cfg_wdata
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_UNION;
      cfg.factor <= '0;
      cfg.recip  <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MODE:   cfg.mode   <= mode_t'(cfg_wdata[ModeW-1:0]);
        REG_FACTOR: cfg.factor <= cfg_wdata;
        REG_RECIP:  cfg.recip  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sdfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_dist    ($signed(s_tdata)),
    .in_last    (s_tlast),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  sdfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  sdfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_dist   (m_tdata)
  );

endmodule

[verif/tb_top.sv]
module tb_top;
  import sdfc_pkg::*;

  localparam int     DrainCycles = 24;
  localparam int     QuietLimit  = 1000;
  localparam longint QOne        = 65536;
  localparam longint QHalf       = 32768;
  localparam longint DistHi      = 64'sd2147483647;
  localparam longint DistLo      = -64'sd2147483648;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  wire              s_tready;
  logic [DistW-1:0] s_tdata = '0;   // [31:0] child_distance
  logic             s_tlast = 1'b0; // last_child
  wire              m_tvalid;
  logic             m_tready = 1'b0;
  wire  [DistW-1:0] m_tdata;        // [31:0] combined_distance
  logic             cfg_we = 1'b0;
  reg_index_t       cfg_index = REG_MODE;
  logic [CoefW-1:0] cfg_wdata = '0;

  // predictor copy of the registers and the open run
  mode_t                   cur_mode = MODE_UNION;
  logic [CoefW-1:0]        cur_factor = '0;
  logic [CoefW-1:0]        cur_recip = '0;
  logic signed [DistW-1:0] run_acc = '0;
  logic                    run_first = 1'b1;
  logic [DistW-1:0]        pending_dist_q[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int hold_len = 0;
  bit src_idle_on = 1'b1;
  bit stall_on = 1'b1;

  sdf_csg_smooth_combiner dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [DistW-1:0] clip_dist(longint v);
    if (v > DistHi) return DistHi[DistW-1:0];
    if (v < DistLo) return DistLo[DistW-1:0];
    return v[DistW-1:0];
  endfunction

  function automatic logic signed [DistW-1:0] fold_child(logic signed [DistW-1:0] acc_in,
                                                        logic signed [DistW-1:0] d_in);
    longint acc, d, k, rc, x, h, w, r;
    acc = acc_in;
    d   = d_in;
    k   = cur_factor;
    rc  = cur_recip;
    if (cur_factor == 0) begin
      if (cur_mode == MODE_UNION) return (d < acc) ? d_in : acc_in;
      if (cur_mode == MODE_INTER) return (d > acc) ? d_in : acc_in;
      return clip_dist((-d > acc) ? -d : acc);
    end
    x = (cur_mode == MODE_SUB) ? acc + d : d - acc;
    // blend weight: one half shifted by x/(2k), clamped to [0, 1] in Q0.16
    h = (cur_mode == MODE_UNION) ? QHalf + ((x * rc) >>> 17) : QHalf - ((x * rc) >>> 17);
    if (h < 0) h = 0;
    if (h > QOne) h = QOne;
    w = (((k * h) >>> 16) * (QOne - h)) >>> 16;
    if (cur_mode == MODE_UNION)
      r = d + (((acc - d) * h) >>> 16) - w;
    else if (cur_mode == MODE_INTER)
      r = d + (((acc - d) * h) >>> 16) + w;
    else
      r = acc + (((-d - acc) * h) >>> 16) + w;
    return clip_dist(r);
  endfunction

  function automatic void combine_child(logic [DistW-1:0] child, logic last);
    if (run_first || cur_mode == MODE_VOID) run_acc = child;
    else run_acc = fold_child(run_acc, child);
    run_first = last;
    if (last) pending_dist_q.push_back((cur_mode == MODE_VOID) ? DIST_MAX : run_acc);
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) combine_child(s_tdata, s_tlast);
  end

  always @(posedge clk) begin : check_result
    logic [DistW-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dist_q.size() == 0) begin
        $error("combined_distance: expected nothing, actual %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_dist_q.pop_front();
        if (m_tdata !== want) begin
          $error("combined_distance: expected %h, actual %h", want, m_tdata);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, or a long hold-off on request
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        m_tready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_child(logic [DistW-1:0] child, logic last);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= child;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // drop valid, drain all results, then let the back end finish queued children
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dist_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CoefW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode = mode_t'(val[ModeW-1:0]);
      REG_FACTOR: cur_factor = val;
      REG_RECIP:  cur_recip = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_config();
    logic [CoefW-1:0] k, rk;
    logic [63:0]      q;
    int               sel;
    sel = $urandom_range(0, 9);
    write_reg(REG_MODE, CoefW'((sel == 9) ? MODE_VOID : mode_t'(sel % 3)));
    case ($urandom_range(0, 4))
      0:       k = '0;
      1:       k = '1;
      2:       k = CoefW'($urandom_range(1, 1 << 20));
      3:       k = CoefW'($urandom_range(1 << 12, 1 << 18));
      default: k = CoefW'($urandom);
    endcase
    if (k == 0 || $urandom_range(0, 5) == 0) begin
      rk = CoefW'($urandom);
    end else begin
      q  = 64'h1_0000_0000 / k;
      rk = (q > 64'h7FFF_FFFF) ? '1 : q[CoefW-1:0];
    end
    write_reg(REG_FACTOR, k);
    write_reg(REG_RECIP, rk);
    if ($urandom_range(0, 9) == 0) write_reg(REG_NONE, CoefW'($urandom));
  endtask

  // children near a common base so the smooth region is hit, plus fully random values and extremes
  function automatic logic [DistW-1:0] pick_child(logic signed [DistW-1:0] base);
    logic [DistW-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       return r;
      1:       return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return base + ($signed({{16{r[15]}}, r[15:0]}) <<< $urandom_range(0, 8));
    endcase
  endfunction

  task automatic test_hard_union();
    send_child(32'h7FFF_FFFF, 1'b1);
    send_child(32'h0005_0000, 1'b0);
    send_child(-32'sh0003_0000, 1'b0);
    send_child(32'h8000_0000, 1'b1);
  endtask

  task automatic test_hard_inter();
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_INTER));
    send_child(32'h8000_0000, 1'b0);
    send_child(32'h7FFF_FFFF, 1'b0);
    send_child(32'h0000_0000, 1'b1);
  endtask

  task automatic test_hard_sub();
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_SUB));
    // negating the most negative child overflows and saturates
    send_child(32'h0001_0000, 1'b0);
    send_child(32'h8000_0000, 1'b1);
    send_child(-32'sh0002_0000, 1'b0);
    send_child(32'h0001_0000, 1'b1);
  endtask

  task automatic test_smooth_blend();
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_UNION));
    write_reg(REG_FACTOR, 31'h0001_0000);
    write_reg(REG_RECIP, 31'h0001_0000);
    send_child(32'h0000_8000, 1'b0);
    send_child(32'h0000_4000, 1'b1);
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_INTER));
    send_child(32'h0000_8000, 1'b0);
    send_child(-32'sh0000_4000, 1'b1);
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_SUB));
    send_child(32'h0000_8000, 1'b0);
    send_child(-32'sh0000_2000, 1'b1);
    // zero reciprocal pins the weight at one half
    wait_idle();
    write_reg(REG_RECIP, '0);
    send_child(32'h0003_0000, 1'b0);
    send_child(-32'sh0005_0000, 1'b1);
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_UNION));
    write_reg(REG_FACTOR, '1);
    write_reg(REG_RECIP, '1);
    send_child(32'h7FFF_FFFF, 1'b0);
    send_child(32'h8000_0000, 1'b1);
  endtask

  task automatic test_void_mode();
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_VOID));
    send_child(32'h1234_5678, 1'b0);
    send_child(-32'sd5, 1'b1);
    send_child(32'h0002_0000, 1'b0);
    // change mode with the run still open
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_UNION));
    write_reg(REG_NONE, '1);
    send_child(32'h0001_0000, 1'b1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_MODE, CoefW'(MODE_INTER));
    write_reg(REG_FACTOR, '0);
    hold_len = 80;
    repeat (12) send_child($urandom, 1'b1);
  endtask

  task automatic test_random_runs(int n_phases, int per_phase);
    logic signed [DistW-1:0] base;
    for (int p = 0; p < n_phases; p++) begin
      wait_idle();
      random_config();
      base = $signed($urandom) >>> $urandom_range(4, 12);
      for (int i = 0; i < per_phase; i++)
        send_child(pick_child(base), $urandom_range(0, 2) == 0);
    end
  endtask

  task automatic test_steady_stream();
    logic signed [DistW-1:0] base;
    wait_idle();
    src_idle_on = 1'b0;
    stall_on    = 1'b0;
    random_config();
    base = $signed($urandom) >>> 10;
    for (int i = 0; i < 50; i++)
      send_child(pick_child(base), (i == 49) || ($urandom_range(0, 2) == 0));
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_hard_union();
    test_hard_inter();
    test_hard_sub();
    test_smooth_blend();
    test_void_mode();
    test_backpressure();
    test_random_runs(10, 60);
    test_steady_stream();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
